@@ design/vtge_pkg.sv @@
// Shared types, command codes and helper functions for the vector tile geometry encoder.
`default_nettype none

package vtge_pkg;

    localparam int WORD_W  = 32;
    localparam int COORD_W = 32;
    localparam int CNT_W   = 29;
    localparam int MODE_W  = 2;
    localparam int CMD_W   = 3;

    localparam logic [CMD_W-1:0] CMD_MOVE_TO = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LINE_TO = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLOSE   = 3'd7;

    localparam logic [MODE_W-1:0] MODE_POINT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RING   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic REG_ORIGIN_X = 1'b0;
    localparam logic REG_ORIGIN_Y = 1'b1;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_ONE = {{(CNT_W-1){1'b0}}, 1'b1};
    localparam logic [CNT_W-1:0] CNT_TWO = {{(CNT_W-2){1'b0}}, 2'b10};

    // Slot order inside a record: pre command, dx, dy, post command.
    localparam int SLOT_PRE  = 0;
    localparam int SLOT_X    = 1;
    localparam int SLOT_Y    = 2;
    localparam int SLOT_POST = 3;
    localparam int SLOTS     = 4;

    // One classified vertex, ready for word emission.
    typedef struct packed {
        logic              has_pre;
        logic [WORD_W-1:0] pre_word;
        logic              has_xy;
        logic [WORD_W-1:0] zz_x;
        logic [WORD_W-1:0] zz_y;
        logic              has_post;
        logic [WORD_W-1:0] post_word;
        logic              err;
    } t_rec;

    function automatic logic [WORD_W-1:0] cmd_word(input logic [CMD_W-1:0] id,
                                                   input logic [CNT_W-1:0] count);
        cmd_word = {count, id};
    endfunction

    function automatic logic [WORD_W-1:0] zigzag(input logic [WORD_W-1:0] d);
        zigzag = {d[WORD_W-2:0], 1'b0} ^ {WORD_W{d[WORD_W-1]}};
    endfunction

endpackage

`default_nettype wire

@@ design/vtge_front.sv @@
// Front end: origin registers, path state, delta computation and vertex classification.
`default_nettype none

module vtge_front #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [vtge_pkg::COORD_W-1:0]  i_cfg_data,
    input  wire logic                          i_accept,
    input  wire logic [vtge_pkg::MODE_W-1:0]   i_mode,
    input  wire logic                          i_new_feature,
    input  wire logic                          i_first_of_path,
    input  wire logic [vtge_pkg::CNT_W-1:0]    i_path_points,
    input  wire logic [vtge_pkg::COORD_W-1:0]  i_coord_x,
    input  wire logic [vtge_pkg::COORD_W-1:0]  i_coord_y,
    output vtge_pkg::t_rec                     o_rec
);

    localparam int SH = vtge_pkg::COORD_W - COORD_BITS;

    logic [vtge_pkg::COORD_W-1:0] r_origin_x, r_origin_y;
    logic [vtge_pkg::COORD_W-1:0] r_prev_x, r_prev_y, n_prev_x, n_prev_y;
    logic [vtge_pkg::CNT_W-1:0]   r_vidx, r_pcnt, n_vidx, n_pcnt;
    logic [vtge_pkg::MODE_W-1:0]  r_kind, n_kind;

    logic [vtge_pkg::COORD_W-1:0] w_base_x, w_base_y, w_raw_x, w_raw_y;
    logic signed [vtge_pkg::COORD_W-1:0] w_sh_x, w_sh_y, w_dx, w_dy;
    logic [vtge_pkg::CNT_W-1:0]   w_idx, w_cnt, w_line_cnt;
    logic [vtge_pkg::MODE_W-1:0]  w_kind;
    logic                         w_ring, w_extra, w_close, w_zero;

    always_comb begin
        w_base_x = i_new_feature ? r_origin_x : r_prev_x;
        w_base_y = i_new_feature ? r_origin_y : r_prev_y;
        w_idx    = i_first_of_path ? '0 : r_vidx;
        w_cnt    = i_first_of_path ? i_path_points : r_pcnt;
        w_kind   = i_first_of_path ? i_mode : r_kind;
        w_ring   = w_kind[1];

        // wrap to COORD_BITS, then sign-extend back to full width
        w_raw_x = i_coord_x - w_base_x;
        w_raw_y = i_coord_y - w_base_y;
        w_sh_x  = signed'(w_raw_x << SH);
        w_sh_y  = signed'(w_raw_y << SH);
        w_dx    = w_sh_x >>> SH;
        w_dy    = w_sh_y >>> SH;
        w_zero  = (w_dx == '0) && (w_dy == '0);

        w_extra    = (w_idx >= w_cnt);
        w_close    = w_ring && (w_idx == (w_cnt - vtge_pkg::CNT_ONE));
        w_line_cnt = w_cnt - (w_ring ? vtge_pkg::CNT_TWO : vtge_pkg::CNT_ONE);

        o_rec           = '0;
        o_rec.zz_x      = vtge_pkg::zigzag(w_dx);
        o_rec.zz_y      = vtge_pkg::zigzag(w_dy);
        o_rec.has_xy    = 1'b1;
        o_rec.pre_word  = vtge_pkg::cmd_word(vtge_pkg::CMD_MOVE_TO, vtge_pkg::CNT_ONE);
        o_rec.post_word = vtge_pkg::cmd_word(vtge_pkg::CMD_LINE_TO, w_line_cnt);

        if (w_extra) begin
            o_rec.err = 1'b1;
        end else if (w_kind == vtge_pkg::MODE_POINT) begin
            o_rec.has_pre  = (w_idx == '0);
            o_rec.pre_word = vtge_pkg::cmd_word(vtge_pkg::CMD_MOVE_TO, w_cnt);
        end else if (w_idx == '0) begin
            o_rec.has_pre  = 1'b1;
            o_rec.has_post = 1'b1;
            o_rec.err      = (w_cnt < vtge_pkg::CNT_TWO);
        end else if (w_close) begin
            o_rec.has_pre  = 1'b1;
            o_rec.has_xy   = 1'b0;
            o_rec.pre_word = vtge_pkg::cmd_word(vtge_pkg::CMD_CLOSE, vtge_pkg::CNT_ONE);
        end else begin
            o_rec.err = w_zero;
        end

        // closing vertex keeps the (possibly origin-reset) reference
        n_prev_x = (!w_extra && w_kind != vtge_pkg::MODE_POINT && w_idx != '0 && w_close)
                   ? w_base_x : i_coord_x;
        n_prev_y = (!w_extra && w_kind != vtge_pkg::MODE_POINT && w_idx != '0 && w_close)
                   ? w_base_y : i_coord_y;
        n_vidx   = (w_idx < vtge_pkg::CNT_MAX) ? (w_idx + vtge_pkg::CNT_ONE) : w_idx;
        n_pcnt   = w_cnt;
        n_kind   = w_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_vidx     <= '0;
            r_pcnt     <= '0;
            r_kind     <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx == vtge_pkg::REG_ORIGIN_X) begin
                r_origin_x <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == vtge_pkg::REG_ORIGIN_Y) begin
                r_origin_y <= i_cfg_data;
            end
            if (i_accept) begin
                r_prev_x <= n_prev_x;
                r_prev_y <= n_prev_y;
                r_vidx   <= n_vidx;
                r_pcnt   <= n_pcnt;
                r_kind   <= n_kind;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/vtge_queue.sv @@
// Two-entry record queue between front end and word emitter.
`default_nettype none

module vtge_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire vtge_pkg::t_rec i_rec,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output vtge_pkg::t_rec      o_rec
);

    vtge_pkg::t_rec r_mem [2];
    logic           r_wr, r_rd;
    logic [1:0]     r_cnt, n_cnt;
    logic           w_do_push, w_do_pop;

    always_comb begin
        o_full    = (r_cnt == 2'd2);
        o_valid   = (r_cnt != 2'd0);
        o_rec     = r_mem[r_rd];
        w_do_push = i_push && !o_full;
        w_do_pop  = i_pop && o_valid;
        n_cnt     = r_cnt + {1'b0, w_do_push} - {1'b0, w_do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_do_push) r_wr <= ~r_wr;
            if (w_do_pop)  r_rd <= ~r_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

@@ design/vtge_back.sv @@
// Back end: walks the word slots of the head record into a registered output stage.
`default_nettype none

module vtge_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_valid,
    input  wire vtge_pkg::t_rec               i_q_rec,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [vtge_pkg::WORD_W-1:0]       o_word,
    output logic                              o_last_word,
    output logic                              o_error
);

    logic                            r_busy;
    logic [vtge_pkg::SLOTS-1:0]      r_mask, w_mask, w_sel, w_rem;
    logic [vtge_pkg::WORD_W-1:0]     w_word;
    logic                            w_take, w_last;

    always_comb begin
        w_mask = r_busy ? r_mask
                        : {i_q_rec.has_post, i_q_rec.has_xy, i_q_rec.has_xy, i_q_rec.has_pre};
        w_sel  = w_mask & (~w_mask + 4'd1);   // lowest pending slot
        w_rem  = w_mask & ~w_sel;
        w_last = (w_rem == '0);
        case (w_sel)
            4'b0001: w_word = i_q_rec.pre_word;
            4'b0010: w_word = i_q_rec.zz_x;
            4'b0100: w_word = i_q_rec.zz_y;
            4'b1000: w_word = i_q_rec.post_word;
            default: w_word = i_q_rec.pre_word;
        endcase
        w_take = i_q_valid && (!o_valid || !i_stall);
        o_pop  = w_take && w_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            o_word      <= w_word;
            o_last_word <= w_last;
            o_error     <= i_q_rec.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_busy  <= 1'b0;
            r_mask  <= '0;
        end else begin
            if (w_take) begin
                o_valid <= 1'b1;
                r_busy  <= !w_last;
                r_mask  <= w_rem;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/vector_tile_geometry_encoder.sv @@
// Top level of the vector tile geometry command encoder.
//
// Usage: one vertex word enters on the input channel (i_valid / o_stall) with its
// mode, new-feature and first-of-path flags, path point count and x/y coordinates.
// It leaves as 1 to 4 geometry words on the output channel (o_valid / i_stall):
// optional MOVE_TO or close command, zigzag dx, zigzag dy, optional LINE_TO.
// o_last_word marks the final word of a vertex; o_error is set on all its words.
// Origin registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write them only while idle, which the block itself does not enforce.
// A vertex is written into the record queue; its first word is then registered in
// the output stage. Throughput: one word per cycle while i_stall is low; a typical
// vertex is two words, a line or ring head vertex four, a closing vertex one.
// The front end classifies a vertex in the cycle it is accepted; a two-entry record
// queue decouples it from the word emitter, so o_stall rises only when the queue
// is full. A stalled output word holds until taken; the emitter then resumes.
// Reset (synchronous, active low) clears the origins, the previous coordinate,
// path state, the queue and the output valid.
`default_nettype none

module vector_tile_geometry_encoder #(
    parameter int COORD_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic        i_new_feature,
    input  wire logic        i_first_of_path,
    input  wire logic [28:0] i_path_points,
    input  wire logic [31:0] i_coord_x,
    input  wire logic [31:0] i_coord_y,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_word,
    output logic             o_last_word,
    output logic             o_error
);

    vtge_pkg::t_rec w_front_rec, w_q_rec;
    logic           w_accept, w_q_valid, w_pop, w_full;

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    vtge_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (w_accept),
        .i_mode         (i_mode),
        .i_new_feature  (i_new_feature),
        .i_first_of_path(i_first_of_path),
        .i_path_points  (i_path_points),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_rec          (w_front_rec)
    );

    vtge_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_accept),
        .i_rec  (w_front_rec),
        .i_pop  (w_pop),
        .o_full (w_full),
        .o_valid(w_q_valid),
        .o_rec  (w_q_rec)
    );

    vtge_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_rec    (w_q_rec),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_word     (o_word),
        .o_last_word(o_last_word),
        .o_error    (o_error)
    );

    // a record leaves the queue only as its last word enters the output stage
    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (o_valid && o_last_word))
        else $error("queue pop without last word in output stage");

    // full queue stays full until the emitter retires a record
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_full && !w_pop) |=> w_full)
        else $error("queue full flag dropped without a pop");

    // pending work and a free output stage always produce a word
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_valid && (!o_valid || !i_stall)) |=> o_valid)
        else $error("output stage idle while queue holds work");

    // reset leaves the output channel empty
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
